[hw/rtl/jkv_pkg.sv]
// Shared constants, codes and helpers for the JSON key/value extractor.
`timescale 1ns / 1ps

package jkv_pkg;

    localparam int KEY_MAX_CHARS_DEF = 16;
    // key storage never exceeds two 64-bit register words
    localparam int KEY_HW_CHARS      = 16;
    localparam int CHAR_W            = 8;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 2;
    localparam int KEY_LEN_W         = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH   = 2'd2;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_END       = 2'd1,
        KIND_NOT_FOUND = 2'd2,
        KIND_NO_VALUE  = 2'd3
    } kind_t;

    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_DASH       = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LBRACE     = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_COMMA      = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h22;
    localparam logic [CHAR_W-1:0] CH_RBRACE     = 8'h7D;

    function automatic logic is_word_char(input logic [CHAR_W-1:0] ch);
        return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
               (ch >= 8'h61 && ch <= 8'h7A) || ch == CH_UNDERSCORE || ch == CH_DASH;
    endfunction

endpackage

[hw/rtl/jkv_key_store.sv]
// Key configuration registers: key length clamp and key character select.
`timescale 1ns / 1ps

module jkv_key_store
    import jkv_pkg::*;
#(
    parameter int KEY_MAX_CHARS = KEY_MAX_CHARS_DEF,
    localparam int KEY_CHARS = (KEY_MAX_CHARS < KEY_HW_CHARS) ? KEY_MAX_CHARS : KEY_HW_CHARS,
    localparam int IDX_W = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1,
    localparam int LEN_W = $clog2(KEY_CHARS + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [IDX_W-1:0]       sel,
    output logic [CHAR_W-1:0]      key_char,
    output logic [LEN_W-1:0]       key_len
);

    logic [KEY_LEN_W-1:0] key_length_reg;
    logic [CHAR_W-1:0]    key_reg [KEY_CHARS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= '0;
        end
        else if (cfg_write && cfg_index == REG_KEY_LENGTH)
        begin
            key_length_reg <= cfg_data[KEY_LEN_W-1:0];
        end
    end

    for (genvar i = 0; i < KEY_CHARS; i++)
    begin : g_key
        if (i < 8)
        begin : g_low
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    key_reg[i] <= '0;
                else if (cfg_write && cfg_index == REG_KEY_LOW)
                    key_reg[i] <= cfg_data[CHAR_W*i +: CHAR_W];
            end
        end
        else
        begin : g_high
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    key_reg[i] <= '0;
                else if (cfg_write && cfg_index == REG_KEY_HIGH)
                    key_reg[i] <= cfg_data[CHAR_W*(i-8) +: CHAR_W];
            end
        end
    end

    // effective length is the configured length clamped to the stored chars
    assign key_len  = (key_length_reg > KEY_LEN_W'(KEY_CHARS)) ? LEN_W'(KEY_CHARS)
                                                              : key_length_reg[LEN_W-1:0];
    assign key_char = key_reg[sel];

endmodule

[hw/rtl/json_key_value_extract_unit.sv]
// JSON key/value extractor top level: character scan, state and result buffer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | input     | in_valid/in_ready  | text_char, end_of_text
//   out     | output    | out_valid/out_ready| value_char, kind, last
//   cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// One request per cycle while in_ready is high; the scan step is one compare against one key char.
// A result is registered in the result register, or in the skid while that register is held.
// A two-entry output buffer (result register plus skid) keeps input flowing
// while a result waits; in_ready drops only when both entries are full.
// Reset clears scan state, key registers and both buffer entries.
`timescale 1ns / 1ps

module json_key_value_extract_unit
    import jkv_pkg::*;
#(
    parameter int KEY_MAX_CHARS = KEY_MAX_CHARS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CHAR_W-1:0]      text_char,
    input  logic                   end_of_text,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CHAR_W-1:0]      value_char,
    output logic [1:0]             kind,
    output logic                   last,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int KEY_CHARS = (KEY_MAX_CHARS < KEY_HW_CHARS) ? KEY_MAX_CHARS : KEY_HW_CHARS;
    localparam int IDX_W = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int LEN_W = $clog2(KEY_CHARS + 1);

    typedef enum logic [2:0] {
        MODE_SEARCH,
        MODE_MATCH,
        MODE_SEEK,
        MODE_COPY,
        MODE_DONE
    } mode_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        kind_t             kind;
        logic              last;
    } result_t;

    mode_t              mode_reg, mode_next;
    logic               ikp_reg, ikp_next;
    logic               prev_reg, prev_next;
    logic [IDX_W-1:0]   mi_reg, mi_next;

    result_t            out_reg, skid_reg, res;
    logic               out_valid_reg, skid_valid_reg;
    logic               has_res;

    logic [IDX_W-1:0]   key_sel;
    logic [CHAR_W-1:0]  key_char;
    logic [LEN_W-1:0]   key_len;
    logic               in_fire, push, pop;

    jkv_key_store #(
        .KEY_MAX_CHARS(KEY_MAX_CHARS)
    ) u_key_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .sel      (key_sel),
        .key_char (key_char),
        .key_len  (key_len)
    );

    assign key_sel = (mode_reg == MODE_MATCH) ? mi_reg : '0;

    always_comb
    begin
        logic             w;
        logic             ikp_now;
        logic             seek_go;
        logic [LEN_W-1:0] mi_inc;

        w       = is_word_char(text_char);
        ikp_now = ikp_reg || text_char == CH_LBRACE || text_char == CH_COMMA;
        seek_go = 1'b0;
        mi_inc  = LEN_W'(mi_reg) + LEN_W'(1);

        mode_next = mode_reg;
        ikp_next  = ikp_reg;
        prev_next = prev_reg;
        mi_next   = mi_reg;
        has_res   = 1'b0;
        res.ch    = '0;
        res.kind  = KIND_CHAR;
        res.last  = 1'b0;

        if (end_of_text)
        begin
            unique case (mode_reg)
                MODE_SEARCH, MODE_MATCH:
                begin
                    has_res  = 1'b1;
                    res.kind = KIND_NOT_FOUND;
                    res.last = 1'b1;
                end
                MODE_SEEK:
                begin
                    has_res  = 1'b1;
                    res.kind = KIND_NO_VALUE;
                    res.last = 1'b1;
                end
                MODE_COPY:
                begin
                    has_res  = 1'b1;
                    res.kind = KIND_END;
                    res.last = 1'b1;
                end
                default: ;
            endcase
            mode_next = MODE_SEARCH;
            ikp_next  = 1'b0;
            prev_next = 1'b0;
            mi_next   = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_COPY:
                begin
                    has_res = 1'b1;
                    if (text_char == CH_QUOTE || text_char == CH_COMMA ||
                        text_char == CH_RBRACE)
                    begin
                        mode_next = MODE_DONE;
                        res.kind  = KIND_END;
                        res.last  = 1'b1;
                    end
                    else
                    begin
                        res.ch = text_char;
                    end
                end
                MODE_MATCH:
                begin
                    if (w && text_char == key_char)
                    begin
                        if (mi_inc >= key_len)
                        begin
                            mode_next = MODE_SEEK;
                            mi_next   = '0;
                        end
                        else
                        begin
                            mi_next = mi_inc[IDX_W-1:0];
                        end
                    end
                    else
                    begin
                        mode_next = MODE_SEARCH;
                        mi_next   = '0;
                    end
                    prev_next = w;
                end
                MODE_SEARCH:
                begin
                    ikp_next  = ikp_now;
                    prev_next = w;
                    if (ikp_now)
                    begin
                        priority if (key_len == '0)
                        begin
                            // empty key: value search starts on this same char
                            mode_next = MODE_SEEK;
                            seek_go   = 1'b1;
                        end
                        else if (w && !prev_reg)
                        begin
                            prev_next = 1'b1;
                            if (text_char == key_char)
                            begin
                                if (key_len == LEN_W'(1))
                                begin
                                    mode_next = MODE_SEEK;
                                end
                                else
                                begin
                                    mode_next = MODE_MATCH;
                                    mi_next   = IDX_W'(1);
                                end
                            end
                        end
                        else if (text_char == CH_COLON)
                        begin
                            ikp_next = 1'b0;
                        end
                    end
                end
                MODE_SEEK:
                begin
                    seek_go = 1'b1;
                end
                default: ;
            endcase

            if (seek_go)
            begin
                if (w && !prev_reg)
                begin
                    mode_next = MODE_COPY;
                    prev_next = 1'b1;
                    has_res   = 1'b1;
                    res.ch    = text_char;
                end
                else
                begin
                    prev_next = w;
                end
            end
        end
    end

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign push     = in_fire && has_res;
    assign pop      = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SEARCH;
            ikp_reg  <= 1'b0;
            prev_reg <= 1'b0;
            mi_reg   <= '0;
        end
        else if (in_fire)
        begin
            mode_reg <= mode_next;
            ikp_reg  <= ikp_next;
            prev_reg <= prev_next;
            mi_reg   <= mi_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value_char = out_reg.ch;
    assign kind       = out_reg.kind;
    assign last       = out_reg.last;

endmodule
